// File: hdl/lfp_pkg.sv
// ----------------------------------------------------------------------------
// Frame parser package
// Phase encoding, result kinds, delimiters and the data count helper.
// ----------------------------------------------------------------------------
package lfp_pkg;

    localparam logic [7:0] START_DELIM = 8'h3C;
    localparam logic [7:0] END_DELIM   = 8'h3E;
    localparam logic [9:0] LEN_FIELDS  = 10'd2;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_TOTAL = 3'd1,
        PH_CLEN  = 3'd2,
        PH_CMD   = 3'd3,
        PH_FLEN  = 3'd4,
        PH_FMT   = 3'd5,
        PH_DATA  = 3'd6,
        PH_END   = 3'd7
    } phase_t;

    typedef logic [2:0] kind_t;

    localparam kind_t K_HEADER = 3'd0;
    localparam kind_t K_CMD    = 3'd1;
    localparam kind_t K_FMT    = 3'd2;
    localparam kind_t K_DATA   = 3'd3;
    localparam kind_t K_DONE   = 3'd4;
    localparam kind_t K_ERR    = 3'd5;

    // total - 2 - command length - format length, clamped at zero
    function automatic logic [7:0] data_count(
        input logic [7:0] total,
        input logic [7:0] cmd,
        input logic [7:0] fmt
    );
        logic [9:0] used;
        logic [9:0] tot;
        used = {2'b00, cmd} + {2'b00, fmt} + LEN_FIELDS;
        tot  = {2'b00, total};
        if (used > tot) begin
            data_count = 8'd0;
        end else begin
            data_count = 8'(tot - used);
        end
    endfunction

endpackage

// File: hdl/length_prefixed_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// Length-prefixed frame parser
// Parses '<', total, command length, command, format length, format, data,
// '>' one byte per request and tags each byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_valid/s_ready/s_rx_byte carries one received byte per
//   request. Result channel m_valid/m_ready carries exactly one result per
//   byte: m_kind tags it as header, command, format or data, or reports
//   frame completion with m_cmd_len, m_format_len and m_data_len, or a
//   framing error on a bad start or end delimiter (parser returns to idle).
//   The result of an accepted byte is registered and presented in the next
//   cycle. Throughput is one byte per cycle while m_ready holds high, set
//   by the single phase register update and the result register.
//   The result register holds while m_ready is low; s_ready falls only when
//   that register is full and not being drained, so a new byte is taken in
//   the same cycle the previous result leaves.
//   Synchronous active-low reset puts the parser in idle, waiting for '<',
//   clears the latched lengths and empties the result register.
// ----------------------------------------------------------------------------
module length_prefixed_frame_parser_unit
    import lfp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_kind,
    output logic [7:0] m_byte_value,
    output logic [7:0] m_cmd_len,
    output logic [7:0] m_format_len,
    output logic [7:0] m_data_len
);

    phase_t     phase_reg, phase_next;
    logic [7:0] total_len_reg, total_len_next;
    logic [7:0] command_len_reg, command_len_next;
    logic [7:0] fmt_len_reg, fmt_len_next;
    logic [7:0] bytes_left_reg, bytes_left_next;

    logic       m_valid_reg;
    kind_t      kind_reg, kind_next;
    logic [7:0] byte_value_reg, byte_value_next;
    logic [7:0] cmd_len_reg, cmd_len_next;
    logic [7:0] format_len_reg, format_len_next;
    logic [7:0] data_len_reg, data_len_next;

    logic       accept;
    logic [7:0] fmt_sel;
    logic [7:0] dcount;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign fmt_sel = (phase_reg == PH_FLEN) ? s_rx_byte : fmt_len_reg;
    assign dcount  = data_count(total_len_reg, command_len_reg, fmt_sel);

    always_comb begin
        phase_next       = phase_reg;
        total_len_next   = total_len_reg;
        command_len_next = command_len_reg;
        fmt_len_next     = fmt_len_reg;
        bytes_left_next  = bytes_left_reg;
        kind_next        = K_HEADER;
        byte_value_next  = 8'd0;
        cmd_len_next     = 8'd0;
        format_len_next  = 8'd0;
        data_len_next    = 8'd0;
        case (phase_reg)
            PH_IDLE: begin
                if (s_rx_byte == START_DELIM) begin
                    phase_next = PH_TOTAL;
                end else begin
                    kind_next = K_ERR;
                end
            end
            PH_TOTAL: begin
                total_len_next = s_rx_byte;
                phase_next     = PH_CLEN;
            end
            PH_CLEN: begin
                command_len_next = s_rx_byte;
                bytes_left_next  = s_rx_byte;
                phase_next       = (s_rx_byte != 8'd0) ? PH_CMD : PH_FLEN;
            end
            PH_CMD: begin
                kind_next       = K_CMD;
                byte_value_next = s_rx_byte;
                bytes_left_next = bytes_left_reg - 8'd1;
                if (bytes_left_reg == 8'd1) begin
                    phase_next = PH_FLEN;
                end
            end
            PH_FLEN: begin
                fmt_len_next = s_rx_byte;
                if (s_rx_byte != 8'd0) begin
                    bytes_left_next = s_rx_byte;
                    phase_next      = PH_FMT;
                end else begin
                    bytes_left_next = dcount;
                    phase_next      = (dcount != 8'd0) ? PH_DATA : PH_END;
                end
            end
            PH_FMT: begin
                kind_next       = K_FMT;
                byte_value_next = s_rx_byte;
                bytes_left_next = bytes_left_reg - 8'd1;
                if (bytes_left_reg == 8'd1) begin
                    bytes_left_next = dcount;
                    phase_next      = (dcount != 8'd0) ? PH_DATA : PH_END;
                end
            end
            PH_DATA: begin
                kind_next       = K_DATA;
                byte_value_next = s_rx_byte;
                bytes_left_next = bytes_left_reg - 8'd1;
                if (bytes_left_reg == 8'd1) begin
                    phase_next = PH_END;
                end
            end
            PH_END: begin
                if (s_rx_byte == END_DELIM) begin
                    kind_next       = K_DONE;
                    cmd_len_next    = command_len_reg;
                    format_len_next = fmt_len_reg;
                    data_len_next   = dcount;
                end else begin
                    kind_next = K_ERR;
                end
                phase_next = PH_IDLE;
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            total_len_reg   <= 8'd0;
            command_len_reg <= 8'd0;
            fmt_len_reg     <= 8'd0;
            bytes_left_reg  <= 8'd0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg       <= phase_next;
                total_len_reg   <= total_len_next;
                command_len_reg <= command_len_next;
                fmt_len_reg     <= fmt_len_next;
                bytes_left_reg  <= bytes_left_next;
                m_valid_reg     <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg       <= kind_next;
            byte_value_reg <= byte_value_next;
            cmd_len_reg    <= cmd_len_next;
            format_len_reg <= format_len_next;
            data_len_reg   <= data_len_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = kind_reg;
    assign m_byte_value = byte_value_reg;
    assign m_cmd_len    = cmd_len_reg;
    assign m_format_len = format_len_reg;
    assign m_data_len   = data_len_reg;

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !s_ready)
        else $error("input taken while result register is stalled");

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("accepted byte produced no result");

    a_bad_start_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && phase_reg == PH_IDLE && s_rx_byte != START_DELIM)
        |=> (kind_reg == K_ERR && phase_reg == PH_IDLE))
        else $error("bad start delimiter not reported");

    a_section_count_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_CMD || phase_reg == PH_FMT || phase_reg == PH_DATA)
        |-> bytes_left_reg != 8'd0)
        else $error("section phase entered with zero bytes left");

endmodule
